// ----- sv/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement: shared types and constants
// Field widths of the reference and result words, and the queue word type.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int PAGE_W      = 16;  // page field width on the ports
    localparam int FRAME_OUT_W = 4;   // reported frame index width
    localparam int FAULT_W     = 16;  // fault counter width
    localparam int CFG_W       = 5;   // frames_in_use register width
    localparam int CFG_RESET   = 16;  // frames_in_use after reset

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    // One page reference as it travels through the queue.
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              end_of_string;
    } lpr_item_t;

    // One result word.
    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [FAULT_W-1:0]     fault_count;
    } lpr_result_t;

endpackage

// ----- sv/lpr_in_if.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement: reference channel
// Valid/ready channel that carries one page reference per word.
// ----------------------------------------------------------------------------
interface lpr_in_if
    import lpr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;
    logic              end_of_string;

    modport source (output valid, output page, output end_of_string, input ready);
    modport sink   (input valid, input page, input end_of_string, output ready);
endinterface

// ----- sv/lpr_out_if.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement: result channel
// Valid/ready channel that carries one result word per reference.
// ----------------------------------------------------------------------------
interface lpr_out_if
    import lpr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_count;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

// ----- sv/lpr_front.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement: front end
// Accept reference words, mask the page number and queue them for the back end.
// ----------------------------------------------------------------------------
module lpr_front
    import lpr_pkg::*;
#(
    parameter int PAGE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lpr_in_if.sink     in_ch,
    output logic       q_valid,
    output lpr_item_t  q_item,
    input  logic       q_pop
);

    localparam int STORE_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam logic [PAGE_W-1:0] PAGE_MASK = {PAGE_W{1'b1}} >> (PAGE_W - STORE_W);
    localparam logic [1:0] Q_DEPTH = 2'd2;

    lpr_item_t  slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, wr_ptr_reg;
    logic       push;

    assign in_ch.ready = (count_reg != Q_DEPTH);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != 2'd0);
    assign q_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Drop page bits above the stored width.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].page          <= in_ch.page & PAGE_MASK;
            slot_reg[wr_ptr_reg].end_of_string <= in_ch.end_of_string;
        end
    end

endmodule

// ----- sv/lpr_back.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement: back end
// Frame table, recency ranks, lookup and update sequencer, result register.
// ----------------------------------------------------------------------------
module lpr_back
    import lpr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             q_valid,
    input  lpr_item_t        q_item,
    output logic             q_pop,
    lpr_out_if.source        out_ch
);

    localparam int STORE_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int RESET_N = (CFG_RESET > FRAMES) ? FRAMES : CFG_RESET;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [STORE_W-1:0] page_reg [FRAMES];
    logic [IDX_W-1:0]   rank_reg [FRAMES];
    logic [IDX_W-1:0]   rank_next [FRAMES];
    logic [FRAMES-1:0]  valid_reg, valid_next;
    logic [FRAMES-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]   vcount_reg, vcount_next;
    logic [FAULT_W-1:0] faults_reg, faults_next;

    lpr_item_t          cur_reg;
    logic [FRAMES-1:0]  hit_vec_reg, fill_vec_reg, victim_vec_reg;
    logic               hit_any_reg, fill_any_reg;
    logic [FRAMES-1:0]  hit_raw, fill_raw, is_min;

    logic [FRAMES-1:0]  sel_vec;
    logic [IDX_W-1:0]   sel_idx;
    logic [IDX_W-1:0]   sel_rank;
    logic [STORE_W-1:0] sel_page;
    logic               upd_fire;
    logic               do_touch;
    logic [6:0]         n_wide, n_clamp;

    lpr_result_t        res_reg, res_next;
    logic               out_valid_reg;

    // ---------------- configuration ----------------
    always_comb
    begin
        n_wide  = {2'b00, cfg_wdata};
        n_clamp = n_wide;
        if (n_wide == 7'd0)
        begin
            n_clamp = 7'd1;
        end
        else if (n_wide > 7'(FRAMES))
        begin
            n_clamp = 7'(FRAMES);
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            active_next[i] = (7'(i) < n_clamp);
        end
    end

    // ---------------- sequencer ----------------
    assign upd_fire = (state_reg == S_UPD) && (!out_valid_reg || out_ch.ready);
    assign q_pop    = q_valid && ((state_reg == S_IDLE) || upd_fire);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = q_pop ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- lookup ----------------
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            hit_raw[i]  = active_reg[i] && valid_reg[i]
                          && (page_reg[i] == cur_reg.page[STORE_W-1:0]);
            fill_raw[i] = active_reg[i] && !valid_reg[i];
            is_min[i]   = active_reg[i];
            for (int j = 0; j < FRAMES; j++)
            begin
                if (active_reg[j] && (rank_reg[j] < rank_reg[i]))
                begin
                    is_min[i] = 1'b0;
                end
            end
        end
    end

    // Keep the lowest-numbered match only.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == S_LOOK)
        begin
            hit_vec_reg    <= hit_raw & (~hit_raw + FRAMES'(1));
            fill_vec_reg   <= fill_raw & (~fill_raw + FRAMES'(1));
            victim_vec_reg <= is_min & (~is_min + FRAMES'(1));
            hit_any_reg    <= |hit_raw;
            fill_any_reg   <= |fill_raw;
        end
    end

    // ---------------- update ----------------
    always_comb
    begin
        if (hit_any_reg)
        begin
            sel_vec = hit_vec_reg;
        end
        else if (fill_any_reg)
        begin
            sel_vec = fill_vec_reg;
        end
        else
        begin
            sel_vec = victim_vec_reg;
        end
        sel_idx  = '0;
        sel_rank = '0;
        sel_page = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (sel_vec[i])
            begin
                sel_idx  = sel_idx | IDX_W'(i);
                sel_rank = sel_rank | rank_reg[i];
                sel_page = sel_page | page_reg[i];
            end
        end
    end

    assign do_touch = hit_any_reg || !fill_any_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        vcount_next = vcount_reg;
        faults_next = faults_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (do_touch)
        begin
            // Move the chosen frame to the most recent end.
            for (int i = 0; i < FRAMES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] > sel_rank))
                begin
                    rank_next[i] = rank_reg[i] - IDX_W'(1);
                end
            end
            rank_next[sel_idx] = IDX_W'(vcount_reg - CNT_W'(1));
        end
        else
        begin
            rank_next[sel_idx]  = IDX_W'(vcount_reg);
            valid_next[sel_idx] = 1'b1;
            vcount_next         = vcount_reg + CNT_W'(1);
        end

        if (!hit_any_reg && (faults_reg != FAULT_MAX))
        begin
            faults_next = faults_reg + FAULT_W'(1);
        end

        res_next.hit           = hit_any_reg;
        res_next.frame_index   = FRAME_OUT_W'(sel_idx);
        res_next.evicted_valid = !hit_any_reg && !fill_any_reg;
        res_next.evicted_page  = (!hit_any_reg && !fill_any_reg) ? PAGE_W'(sel_page) : '0;
        res_next.fault_count   = faults_next;

        // Clear the string after its last reference.
        if (cur_reg.end_of_string)
        begin
            valid_next  = '0;
            vcount_next = '0;
            faults_next = '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            vcount_reg    <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i]   <= '0;
                active_reg[i] <= (i < RESET_N);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                active_reg <= active_next;
            end
            if (upd_fire)
            begin
                valid_reg  <= valid_next;
                vcount_reg <= vcount_next;
                faults_reg <= faults_next;
                for (int i = 0; i < FRAMES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            res_reg <= res_next;
            if (!hit_any_reg)
            begin
                page_reg[sel_idx] <= cur_reg.page[STORE_W-1:0];
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.hit           = res_reg.hit;
    assign out_ch.frame_index   = res_reg.frame_index;
    assign out_ch.evicted_valid = res_reg.evicted_valid;
    assign out_ch.evicted_page  = res_reg.evicted_page;
    assign out_ch.fault_count   = res_reg.fault_count;

    // ---------------- checks ----------------
    a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg == CNT_W'($countones(valid_reg)))
        else $error("valid count out of step with valid bits");

    a_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) && !hit_any_reg && !fill_any_reg |-> $onehot(victim_vec_reg))
        else $error("no unique least recently used frame");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire && cur_reg.end_of_string |=> (valid_reg == '0) && (faults_reg == '0))
        else $error("string not cleared after its last reference");

    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.hit && res_reg.evicted_valid))
        else $error("hit reported with an eviction");

endmodule

// ----- sv/lru_page_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Looks up page references among the active frames, fills or replaces the
// least recently used frame on a fault, and reports one result per reference.
// ----------------------------------------------------------------------------
// Path: input queue, current reference, lookup vectors, result register.
// References go one at a time: a lookup step, then an update step; both share
//   the frame table and recency ranks, and a held result stalls the update.
// Input queue holds 2 words; the result register frees the back end when taken.
// Reset: frames empty, ranks and fault count zero, frames_in_use = 16;
//   no clearing pass, the unit accepts words right after reset.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit
    import lpr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    lpr_in_if.sink           in_ch,
    lpr_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // Queue between front and back: the back end pops one word per item.
    logic      q_valid;
    logic      q_pop;
    lpr_item_t q_item;

    // Front: accept reference words, mask the page, hold them in a short queue.
    lpr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // Back: a lookup step, then an update of frame state and result.
    // Advance only when the result register is free or being taken.
    lpr_back #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement unit: self-checking testbench
// Drives page references over the valid/ready channel and checks every result
// word against a typed result or the LRU predictor in the bench: a directed
// table, a short all-fault run, then random reference strings with locality.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import lpr_pkg::*;

    localparam int FRAME_SLOTS  = 16;    // frames built into the unit
    localparam int DRAIN_CYCLES = 8;     // quiet cycles after the last owed result
    localparam int HOLD_CYCLES  = 100;   // long result hold-off for back pressure
    localparam int IDLE_LIMIT   = 1000;  // cycles with no word moving on either channel
    localparam int RANDOM_WORDS = 360;
    localparam int SAT_WORDS    = 24;    // one frame, every reference a fault

    typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

    // One line of the directed table: a reference, or a frames_in_use write.
    typedef struct {
        row_kind_t         kind;
        logic [PAGE_W-1:0] page;
        logic              eos;
        logic [CFG_W-1:0]  frames;
        bit                golden_on;
        lpr_result_t       golden;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lpr_in_if  in_ch ();
    lpr_out_if out_ch ();

    lru_page_replacement_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the frame table and the register
    // ------------------------------------------------------------------------
    logic [PAGE_W-1:0]  mdl_page  [FRAME_SLOTS];
    bit                 mdl_valid [FRAME_SLOTS];
    int                 mdl_rank  [FRAME_SLOTS];
    logic [FAULT_W-1:0] mdl_faults;
    logic [CFG_W-1:0]   mdl_frames;

    lpr_result_t pending_results[$];  // results owed by the unit, oldest first
    int          mismatches;

    // Typed expectation that rides along with the word on the input channel.
    bit          golden_on;
    lpr_result_t golden_word;

    // Idling controls shared between the stimulus and the two channel ends.
    bit tx_rush;    // sender offers back to back
    bit rx_rush;    // receiver never stalls
    bit tx_calm;    // a stretch with no sender gaps
    bit hold_req;   // ask the receiver for one long hold-off

    plan_row_t plan[$];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int valid_frames();
        int n;
        n = 0;
        for (int i = 0; i < FRAME_SLOTS; i++)
            if (mdl_valid[i])
                n++;
        return n;
    endfunction

    // Make frame f the most recently used; everyone above its rank slides down.
    function automatic void promote_frame(int f);
        int r;
        int n;
        r = mdl_rank[f];
        n = valid_frames();
        for (int i = 0; i < FRAME_SLOTS; i++)
            if (mdl_valid[i] && mdl_rank[i] > r)
                mdl_rank[i]--;
        mdl_rank[f] = n - 1;
    endfunction

    function automatic void clear_string();
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_rank[i]  = 0;
        end
        mdl_faults = '0;
    endfunction

    // Look one reference up, update the table, and return the result word.
    function automatic lpr_result_t predict_lookup(logic [PAGE_W-1:0] pg, logic eos);
        lpr_result_t r;
        int          n;
        int          f;
        int          victim;
        bit          is_hit;
        bit          got_empty;
        r         = '0;
        f         = 0;
        is_hit    = 1'b0;
        got_empty = 1'b0;
        // Out-of-range counts clamp: 0 acts as 1, anything above the slots as all.
        n = int'(mdl_frames);
        if (n < 1)
            n = 1;
        if (n > FRAME_SLOTS)
            n = FRAME_SLOTS;

        // Only active frames are searched; frames above the count keep their state.
        for (int i = 0; i < n; i++)
            if (!is_hit && mdl_valid[i] && mdl_page[i] == pg)
            begin
                f      = i;
                is_hit = 1'b1;
            end

        if (is_hit)
            promote_frame(f);
        else
        begin
            for (int i = 0; i < n; i++)
                if (!got_empty && !mdl_valid[i])
                begin
                    f         = i;
                    got_empty = 1'b1;
                end
            if (got_empty)
            begin
                mdl_rank[f]  = valid_frames();
                mdl_valid[f] = 1'b1;
                mdl_page[f]  = pg;
            end
            else
            begin
                // Every active frame is full: the lowest rank goes.
                victim = 0;
                for (int i = 1; i < n; i++)
                    if (mdl_rank[i] < mdl_rank[victim])
                        victim = i;
                f               = victim;
                r.evicted_valid = 1'b1;
                r.evicted_page  = mdl_page[f];
                mdl_page[f]     = pg;
                promote_frame(f);
            end
            if (mdl_faults != FAULT_MAX)
                mdl_faults++;
        end

        r.hit         = is_hit;
        r.frame_index = FRAME_OUT_W'(f);
        r.fault_count = mdl_faults;
        if (eos)
            clear_string();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [PAGE_W-1:0] want, logic [PAGE_W-1:0] got);
        if (got !== want)
            flag_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    // Sample both channels at the rising edge; inputs only move on the falling
    // edge, so every value read here is settled.
    always @(posedge clk)
    begin : monitor
        lpr_result_t pred;
        lpr_result_t want;
        lpr_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_SLOTS; i++)
                mdl_page[i] = '0;
            clear_string();
            mdl_frames = CFG_W'(CFG_RESET);
        end
        else
        begin
            if (cfg_we)
                mdl_frames = cfg_wdata;

            // Advance the predictor on every accepted reference; a directed row
            // with a typed result replaces the predicted one.
            if (in_ch.valid && in_ch.ready)
            begin
                pred = predict_lookup(in_ch.page, in_ch.end_of_string);
                pending_results.push_back(golden_on ? golden_word : pred);
            end

            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.hit, out_ch.frame_index, out_ch.evicted_valid,
                       out_ch.evicted_page, out_ch.fault_count};
                if (pending_results.size() == 0)
                    flag_mismatch("result word with no reference outstanding");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("hit", PAGE_W'(want.hit), PAGE_W'(got.hit));
                    check_field("frame_index", PAGE_W'(want.frame_index),
                                PAGE_W'(got.frame_index));
                    check_field("evicted_valid", PAGE_W'(want.evicted_valid),
                                PAGE_W'(got.evicted_valid));
                    check_field("evicted_page", want.evicted_page, got.evicted_page);
                    check_field("fault_count", want.fault_count, got.fault_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no word moves on either channel for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL lru_page_replacement_unit");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, calm stretches, and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        bit calm;
        stall        = 0;
        calm         = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            // Hold results back so the input queue fills and the unit stalls.
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (rx_rush)
                out_ch.ready <= 1'b1;
            else if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
            end
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
        end
    end

    // ------------------------------------------------------------------------
    // Reference side
    // ------------------------------------------------------------------------
    // Gap before the next word: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
        if (tx_rush || tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Offer one reference after the given gap and hold it until it is taken.
    // A zero gap keeps valid high straight into the next word.
    task automatic offer_reference(logic [PAGE_W-1:0] pg, logic eos, bit typed,
                                   lpr_result_t res, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.page          <= pg;
        in_ch.end_of_string <= eos;
        golden_on           <= typed;
        golden_word         <= res;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic drain_unit();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pick a frame count, favoring the extremes and the clamped values.
    function automatic logic [CFG_W-1:0] pick_frames();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(FRAME_SLOTS);
            3:       return '1;
            default: return CFG_W'($urandom_range(0, 31));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [PAGE_W-1:0] ws [24];
        logic [PAGE_W-1:0] pg;
        logic              eos;
        int                ws_size;
        int                str_len;
        int                sent;
        int                cut_at;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.page          = '0;
        in_ch.end_of_string = 1'b0;
        golden_on           = 1'b0;
        golden_word         = '0;
        tx_rush             = 1'b0;
        rx_rush             = 1'b0;
        tx_calm             = 1'b0;
        hold_req            = 1'b0;
        mismatches          = 0;

        // Directed table. Result fields: hit, frame, evicted_valid, evicted_page,
        // fault_count. Rows without a typed result go to the predictor.
        // Page 0 right after reset must fault: empty frames never match.
        plan.push_back('{ROW_REF, 16'h0000, 1'b0, '0, 1'b1, {1'b0, 4'd0, 1'b0, 16'h0, 16'd1}});
        plan.push_back('{ROW_REF, 16'h0000, 1'b0, '0, 1'b1, {1'b1, 4'd0, 1'b0, 16'h0, 16'd1}});
        plan.push_back('{ROW_REF, 16'hFFFF, 1'b0, '0, 1'b1, {1'b0, 4'd1, 1'b0, 16'h0, 16'd2}});
        plan.push_back('{ROW_REF, 16'h5555, 1'b0, '0, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'hAAAA, 1'b0, '0, 1'b0, '0});
        // Hit on the last reference of a string, then the table clears.
        plan.push_back('{ROW_REF, 16'hFFFF, 1'b1, '0, 1'b1, {1'b1, 4'd1, 1'b0, 16'h0, 16'd4}});
        // Two frames: fill both, hit, then replace the least recently used.
        plan.push_back('{ROW_CFG, '0, 1'b0, 5'd2, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'h0001, 1'b0, '0, 1'b1, {1'b0, 4'd0, 1'b0, 16'h0, 16'd1}});
        plan.push_back('{ROW_REF, 16'h0002, 1'b0, '0, 1'b1, {1'b0, 4'd1, 1'b0, 16'h0, 16'd2}});
        plan.push_back('{ROW_REF, 16'h0001, 1'b0, '0, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'h0003, 1'b0, '0, 1'b1, {1'b0, 4'd1, 1'b1, 16'h2, 16'd3}});
        plan.push_back('{ROW_REF, 16'h0002, 1'b0, '0, 1'b0, '0});
        // Count of 0 acts as 1 and is lowered mid-string: frame 1 goes dormant.
        plan.push_back('{ROW_CFG, '0, 1'b0, 5'd0, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'h0003, 1'b0, '0, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'h0003, 1'b0, '0, 1'b0, '0});
        // Count above the slots acts as all of them; dormant frames come back.
        plan.push_back('{ROW_CFG, '0, 1'b0, 5'd31, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'h0007, 1'b0, '0, 1'b0, '0});
        plan.push_back('{ROW_REF, 16'h0003, 1'b1, '0, 1'b0, '0});
        plan.push_back('{ROW_CFG, '0, 1'b0, 5'd16, 1'b0, '0});

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table; register writes only on a drained unit.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_unit();
                write_frames(plan[i].frames);
            end
            else
                offer_reference(plan[i].page, plan[i].eos, plan[i].golden_on,
                                plan[i].golden, pick_gap());
        end

        // Fault on every reference: one frame, two pages taking turns.
        // Run flat out on both sides.
        drain_unit();
        write_frames(CFG_W'(1));
        tx_rush = 1'b1;
        rx_rush = 1'b1;
        for (int i = 0; i < SAT_WORDS; i++)
            offer_reference(i[0] ? 16'h1234 : 16'hEDCB, i == SAT_WORDS - 1, 1'b0, '0, 0);
        rx_rush = 1'b0;
        tx_rush = 1'b0;
        drain_unit();
        write_frames(CFG_W'(FRAME_SLOTS));

        // Random reference strings with a working set, so hits, fills and
        // replacements all come up. The first string runs into a long
        // result hold-off with the sender pushing back to back.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent == 0)
            begin
                hold_req = 1'b1;
                tx_rush  = 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                drain_unit();
                write_frames(pick_frames());
            end

            ws_size = $urandom_range(1, 24);
            for (int k = 0; k < ws_size; k++)
                case ($urandom_range(0, 15))
                    0:       ws[k] = '0;
                    1:       ws[k] = '1;
                    default: ws[k] = PAGE_W'($urandom_range(0, 65535));
                endcase
            str_len = (sent == 0) ? 30 : $urandom_range(4, 40);
            // Sometimes change the frame count partway through the string.
            cut_at  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, str_len - 1) : -1;

            for (int k = 0; k < str_len; k++)
            begin
                if (k == cut_at)
                begin
                    drain_unit();
                    write_frames(pick_frames());
                end
                // Mostly the working set, some stray pages, a rare early clear.
                if ($urandom_range(0, 7) == 0)
                    pg = PAGE_W'($urandom_range(0, 65535));
                else
                    pg = ws[$urandom_range(0, ws_size - 1)];
                eos = (k == str_len - 1) || ($urandom_range(0, 49) == 0);
                offer_reference(pg, eos, 1'b0, '0, pick_gap());
                sent++;
            end
            tx_rush = 1'b0;
        end

        // Wait for the last results, then a few quiet cycles.
        drain_unit();
        if (mismatches == 0)
            $display("PASS lru_page_replacement_unit");
        else
            $display("FAIL lru_page_replacement_unit");
        $finish;
    end

endmodule
